[hdl/upsc_pkg.sv]
// shared types and constants for the pixel replicate upscaler
// no dependencies; used by upsc_ctrl, upsc_line_buf and the top level
`default_nettype none

package upsc_pkg;

  // default sizing of the line store and replication counters
  localparam int WIDTH_MAX_DEF = 1024;
  localparam int SCALE_MAX_DEF = 16;

  // fixed field widths
  localparam int PIX_W       = 24;
  localparam int SCALE_REG_W = 5;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [1:0] {
    KIND_LOADED  = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_PAD     = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_PULL = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_idx_t;

  // per-word result of the sequencer
  typedef struct packed {
    kind_t kind;
    logic  row_end;
    logic  group_end;
  } step_t;

endpackage

`default_nettype wire

[hdl/upsc_line_buf.sv]
// line store for one source row, one write and one registered read port
// depends on upsc_pkg for the pixel width and the default depth
`default_nettype none

module upsc_line_buf #(
  parameter int DEPTH = upsc_pkg::WIDTH_MAX_DEF,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [upsc_pkg::PIX_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [upsc_pkg::PIX_W-1:0] rd_data_r
);

  logic [upsc_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/upsc_ctrl.sv]
// load/pull sequencer: config registers, load column, replication counters
// depends on upsc_pkg for kinds, modes, config indexes and step_t
`default_nettype none

module upsc_ctrl #(
  parameter int WIDTH_MAX = upsc_pkg::WIDTH_MAX_DEF,
  parameter int SCALE_MAX = upsc_pkg::SCALE_MAX_DEF,
  parameter int AW        = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [upsc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [upsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            fire,
  input  wire upsc_pkg::mode_t                 mode,
  output upsc_pkg::step_t                      res,
  output logic                                 wr_en,
  output logic      [AW-1:0]                   wr_addr,
  output logic                                 rd_en,
  output logic      [AW-1:0]                   rd_addr
);

  localparam int WW = AW + 1;
  localparam int CW = (SCALE_MAX > 1) ? $clog2(SCALE_MAX) : 1;
  localparam int SW = CW + 1;

  // effective (clamped) config values
  logic [SW-1:0] scale_r;
  logic [WW-1:0] width_r;
  logic [SW-1:0] scale_wr;
  logic [WW-1:0] width_wr;
  logic [upsc_pkg::SCALE_REG_W-1:0] scale_raw;
  logic [upsc_pkg::WIDTH_REG_W-1:0] width_raw;

  logic [AW-1:0] load_col_r, load_col_nxt;
  logic          owed_r, owed_nxt;
  logic [AW-1:0] src_col_r, src_col_nxt;
  logic [CW-1:0] copy_r, copy_nxt;
  logic [1:0]    pad_cnt_r, pad_cnt_nxt;
  logic [CW-1:0] rep_r, rep_nxt;
  logic          pad_ph_r, pad_ph_nxt;
  logic [1:0]    pad;
  logic [1:0]    ws_lo;

  assign scale_raw = cfg_wdata[upsc_pkg::SCALE_REG_W-1:0];
  assign width_raw = cfg_wdata[upsc_pkg::WIDTH_REG_W-1:0];

  always_comb begin
    if (scale_raw == '0) begin
      scale_wr = SW'(1);
    end else if (32'(scale_raw) > 32'(SCALE_MAX)) begin
      scale_wr = SW'(SCALE_MAX);
    end else begin
      scale_wr = SW'(scale_raw);
    end
    if (width_raw == '0) begin
      width_wr = WW'(1);
    end else if (32'(width_raw) > 32'(WIDTH_MAX)) begin
      width_wr = WW'(WIDTH_MAX);
    end else begin
      width_wr = WW'(width_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SW'(1);
      width_r <= WW'(1);
    end else if (cfg_wr_en) begin
      case (upsc_pkg::cfg_idx_t'(cfg_addr))
        upsc_pkg::CFG_SCALE: scale_r <= scale_wr;
        upsc_pkg::CFG_WIDTH: width_r <= width_wr;
        default: ;
      endcase
    end
  end

  // (w*s*3) mod 4 is -(w*s) mod 4, so the pad count is just (w*s) mod 4
  assign ws_lo = width_r[1:0] * scale_r[1:0];
  assign pad   = ws_lo;

  always_comb begin
    load_col_nxt = load_col_r;
    owed_nxt     = owed_r;
    src_col_nxt  = src_col_r;
    copy_nxt     = copy_r;
    pad_cnt_nxt  = pad_cnt_r;
    rep_nxt      = rep_r;
    pad_ph_nxt   = pad_ph_r;
    res.kind      = upsc_pkg::KIND_REFUSED;
    res.row_end   = 1'b0;
    res.group_end = 1'b0;
    wr_en = 1'b0;
    rd_en = 1'b0;

    case (mode)
      upsc_pkg::MODE_LOAD: begin
        if (!owed_r) begin
          res.kind = upsc_pkg::KIND_LOADED;
          wr_en    = fire;
          if (({1'b0, load_col_r} + WW'(1)) >= width_r) begin
            load_col_nxt = '0;
            owed_nxt     = 1'b1;
            src_col_nxt  = '0;
            copy_nxt     = '0;
            pad_cnt_nxt  = '0;
            rep_nxt      = '0;
            pad_ph_nxt   = 1'b0;
          end else begin
            load_col_nxt = load_col_r + AW'(1);
          end
        end
      end
      upsc_pkg::MODE_PULL: begin
        if (owed_r) begin
          if (!pad_ph_r) begin
            res.kind = upsc_pkg::KIND_PIXEL;
            rd_en    = fire;
            if (({1'b0, copy_r} + SW'(1)) >= scale_r) begin
              copy_nxt = '0;
              if (({1'b0, src_col_r} + WW'(1)) >= width_r) begin
                src_col_nxt = '0;
                if (pad == 2'd0) begin
                  res.row_end = 1'b1;
                end else begin
                  pad_ph_nxt  = 1'b1;
                  pad_cnt_nxt = '0;
                end
              end else begin
                src_col_nxt = src_col_r + AW'(1);
              end
            end else begin
              copy_nxt = copy_r + CW'(1);
            end
          end else begin
            res.kind = upsc_pkg::KIND_PAD;
            if (({1'b0, pad_cnt_r} + 3'd1) >= {1'b0, pad}) begin
              pad_cnt_nxt = '0;
              pad_ph_nxt  = 1'b0;
              res.row_end = 1'b1;
            end else begin
              pad_cnt_nxt = pad_cnt_r + 2'd1;
            end
          end

          if (res.row_end) begin
            if (({1'b0, rep_r} + SW'(1)) >= scale_r) begin
              res.group_end = 1'b1;
              owed_nxt      = 1'b0;
              src_col_nxt   = '0;
              copy_nxt      = '0;
              pad_cnt_nxt   = '0;
              rep_nxt       = '0;
              pad_ph_nxt    = 1'b0;
            end else begin
              rep_nxt = rep_r + CW'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_col_r <= '0;
      owed_r     <= 1'b0;
      src_col_r  <= '0;
      copy_r     <= '0;
      pad_cnt_r  <= '0;
      rep_r      <= '0;
      pad_ph_r   <= 1'b0;
    end else if (fire) begin
      load_col_r <= load_col_nxt;
      owed_r     <= owed_nxt;
      src_col_r  <= src_col_nxt;
      copy_r     <= copy_nxt;
      pad_cnt_r  <= pad_cnt_nxt;
      rep_r      <= rep_nxt;
      pad_ph_r   <= pad_ph_nxt;
    end
  end

  assign wr_addr = load_col_r;
  assign rd_addr = src_col_r;

endmodule

`default_nettype wire

[hdl/pixel_replicate_upscaler_core.sv]
// an accepted input word passes stage one (sequencer + store read), then the output register, to out_tvalid
// throughput: one word per cycle while out_tready is high; in_tready follows out_tready combinationally
// the second stage is there because the line store read port is registered
// reset (rst_n, synchronous, active low) clears the counters, owed flag, valid bits and
// sets scale and width to 1; the line store is not cleared and has no clearing pass
// top level of the pixel replicate upscaler; depends on upsc_pkg, upsc_ctrl, upsc_line_buf
`default_nettype none

module pixel_replicate_upscaler_core #(
  parameter int WIDTH_MAX = upsc_pkg::WIDTH_MAX_DEF,
  parameter int SCALE_MAX = upsc_pkg::SCALE_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_wr_en,
  input  wire logic [upsc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [upsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,   // blue_in, green_in, red_in
  input  wire logic                            in_tuser,   // mode
  // result words
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [23:0]                     out_tdata,  // blue_out, green_out, red_out
  output logic                                 out_tlast,  // end_of_row
  output logic      [2:0]                      out_tuser   // kind[1:0], end_of_group
);

  localparam int AW = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;

  logic                        fire;
  upsc_pkg::step_t             step;
  logic                        st_wr_en;
  logic [AW-1:0]               st_wr_addr;
  logic                        st_rd_en;
  logic [AW-1:0]               st_rd_addr;
  logic [upsc_pkg::PIX_W-1:0]  st_rd_data;

  // stage one: sequencer result waiting on the store read
  logic                        s1_v_r;
  upsc_pkg::step_t             s1_res_r;
  logic                        s1_adv;

  // output register
  logic                        out_v_r;
  upsc_pkg::step_t             out_res_r;
  logic [upsc_pkg::PIX_W-1:0]  out_pix_r;

  // stage one moves on when the output register is empty or being drained
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign fire      = in_tvalid && in_tready;

  upsc_ctrl #(
    .WIDTH_MAX (WIDTH_MAX),
    .SCALE_MAX (SCALE_MAX),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .mode      (upsc_pkg::mode_t'(in_tuser)),
    .res       (step),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .rd_en     (st_rd_en),
    .rd_addr   (st_rd_addr)
  );

  // store word is {red, green, blue}, blue in the low byte as on the bus
  upsc_line_buf #(
    .DEPTH (WIDTH_MAX),
    .AW    (AW)
  ) u_line_buf (
    .clk       (clk),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_data   (in_tdata),
    .rd_en     (st_rd_en),
    .rd_addr   (st_rd_addr),
    .rd_data_r (st_rd_data)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload; the store read data holds until the next pixel pull, which cannot
  // be issued before this stage moves on
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res_r <= step;
    end
    if (s1_adv) begin
      out_res_r <= s1_res_r;
      out_pix_r <= (s1_res_r.kind == upsc_pkg::KIND_PIXEL) ? st_rd_data : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_res_r.row_end;
  assign out_tuser  = {out_res_r.group_end, out_res_r.kind};

  // the last row of a group always ends a row
  a_group_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.group_end |-> out_res_r.row_end)
    else $error("end of group without end of row");

  // pixel bytes only on pixel words
  a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_res_r.kind != upsc_pkg::KIND_PIXEL) |-> (out_pix_r == '0))
    else $error("non-pixel word carries pixel bytes");

  // loads and refusals carry no row flags
  a_flags_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && ((out_res_r.kind == upsc_pkg::KIND_LOADED) ||
                (out_res_r.kind == upsc_pkg::KIND_REFUSED))
    |-> !out_res_r.row_end && !out_res_r.group_end)
    else $error("row flag on load or refused word");

  // an accepted word always lands in stage one
  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> s1_v_r)
    else $error("accepted word lost");

  // input stalls only when both stages are full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && out_v_r && !out_tready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
